// ----- hdl/hadamard_walk_on_ring_defines.svh -----
// Assertion macros shared by the walk-on-ring RTL.
`ifndef HADAMARD_WALK_ON_RING_DEFINES_SVH
`define HADAMARD_WALK_ON_RING_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define HWR_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define HWR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HWR_ASSERT_IMM(lbl, ante, cons, msg)
`define HWR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/hwr_pkg.sv -----
// Package: constants and elaboration helpers for the Hadamard walk on a ring.
`timescale 1ns / 1ps

package hwr_pkg;

    // Default sizing
    localparam int HWR_RING_MAX   = 64;
    localparam int HWR_AMP_WIDTH  = 16;

    // Fixed field widths
    localparam int HWR_CFG_W       = 7;
    localparam int HWR_STEP_W      = 12;
    localparam int HWR_POS_W       = 6;
    localparam int HWR_PROB_W      = 16;
    localparam int HWR_IN_TDATA_W  = 16;
    localparam int HWR_OUT_TDATA_W = 24;

    // Ring positions are capped at what the position field can address
    localparam int HWR_RING_LIMIT  = 64;
    localparam int HWR_RING_RESET  = 64;
    localparam int HWR_PROB_MAX    = 65535;

    // round(2^(amp_w-1) / sqrt2) = round(sqrt(2^(2*amp_w-3))), elaboration only
    function automatic longint unsigned hwr_coin_const(input int amp_w);
        longint unsigned v;
        longint unsigned nv;
        longint unsigned res;
        longint unsigned b;
        v   = 64'd1 << (2 * amp_w - 3);
        nv  = v;
        res = 64'd0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        if (nv > res * res + res) res = res + 64'd1;
        return res;
    endfunction

endpackage

// ----- hdl/hadamard_walk_on_ring.sv -----
// Top level: discrete-time Hadamard quantum walk on a ring, memory based.
//
// Usage: write ring_size on the cfg channel (i_cfg_data, always ready) while the
// block is idle; it is clamped to 2..min(RING_MAX,64) when a run starts.
// Each beat on the s_axis channel (step_count in tdata[11:0]) starts one run.
// The run answers with one m_axis beat per ring position, in position order:
// tdata[5:0] position, tdata[21:6] probability (Q0.16), tlast on the final one.
// Run order for a ring of n positions and s steps:
//   a clear sweep over the n positions, then s walk steps (one position
//   per cycle through the read/coin/multiply/write pipeline, then a drain
//   before the next step reads its ping-pong bank), then the output beats,
//   each read issued only once the previous beat has been taken.
// s_axis is ready only when no run is active: one run at a time.
// Receiver stall: the output register holds its beat; no further read is
// issued until it is taken, so nothing is lost or repeated.
// Reset (synchronous, active low) returns to idle and sets ring_size to 64;
// the amplitude memories need no clearing pass, each run sweeps its bank.
`timescale 1ns / 1ps
`include "hadamard_walk_on_ring_defines.svh"

module hadamard_walk_on_ring #(
    parameter int RING_MAX  = hwr_pkg::HWR_RING_MAX,
    parameter int AMP_WIDTH = hwr_pkg::HWR_AMP_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write channel: ring_size
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hwr_pkg::HWR_CFG_W-1:0]        i_cfg_data,
    // input stream; tdata: [11:0] step_count
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [hwr_pkg::HWR_IN_TDATA_W-1:0]   i_s_axis_tdata,
    // output stream; tdata: [5:0] position, [21:6] probability, [23:22] zero
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [hwr_pkg::HWR_OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);
    import hwr_pkg::*;

    localparam int CAP     = (RING_MAX < HWR_RING_LIMIT) ? RING_MAX : HWR_RING_LIMIT;
    localparam int AW      = $clog2(CAP);
    localparam int LW      = $clog2(CAP + 1);
    localparam int MEM_D   = 2 ** (AW + 1);
    localparam int W       = AMP_WIDTH;
    localparam int KW      = W - 1;
    localparam int MW      = 2 * W;
    localparam int SUMW    = 2 * W + 4;
    localparam int PROB_SH = 2 * W - 18;
    localparam int PAD_W   = HWR_OUT_TDATA_W - HWR_PROB_W - HWR_POS_W;

    localparam logic [KW-1:0]    COIN_K   = KW'(hwr_coin_const(W));
    localparam logic [KW-1:0]    AMP_MAX  = {KW{1'b1}};
    localparam logic [2*W-1:0]   RND_HALF = (2 * W)'(1) << (W - 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_STEP,
        S_DRAIN,
        S_OUT
    } t_state;

    // control
    t_state                 r_state;
    logic [HWR_CFG_W-1:0]   r_ring_size;
    logic [HWR_STEP_W-1:0]  r_steps;
    logic [HWR_STEP_W-1:0]  r_steps_done;
    logic [LW-1:0]          r_len;
    logic [AW-1:0]          r_idx;
    logic                   r_bank;
    logic                   r_v1, r_v2, r_v3;
    logic                   r_ov1, r_ov2;
    logic                   r_o_sent;
    logic                   r_o_valid;

    // memories: {imag, real} of the up part and of the down part, two banks each
    logic [MW-1:0]          r_up_mem [MEM_D];
    logic [MW-1:0]          r_dn_mem [MEM_D];
    logic [MW-1:0]          r_up_rdata;
    logic [MW-1:0]          r_dn_rdata;

    // step pipeline payload
    logic [AW-1:0]          r_up_dst1, r_up_dst2, r_up_dst3;
    logic [AW-1:0]          r_dn_dst1, r_dn_dst2, r_dn_dst3;
    logic signed [W:0]      r_sum  [4];
    logic [2*W-1:0]         r_prod [4];
    logic                   r_neg  [4];

    // output pipeline payload
    logic [AW-1:0]          r_op1_pos, r_op2_pos;
    logic                   r_op1_last, r_op2_last;
    logic [2*W-1:0]         r_sq [4];
    logic [HWR_POS_W-1:0]   r_o_pos;
    logic [HWR_PROB_W-1:0]  r_o_prob;
    logic                   r_o_last;

    // combinational
    logic [LW-1:0]          w_len;
    logic                   w_idx_last;
    logic                   w_o_issue;
    logic [HWR_STEP_W-1:0]  w_steps_next;
    logic [AW-1:0]          w_up_dst, w_dn_dst;
    logic [AW:0]            w_raddr;
    logic                   w_we;
    logic [AW:0]            w_up_waddr, w_dn_waddr;
    logic [MW-1:0]          w_up_wdata, w_dn_wdata;
    logic signed [W-1:0]    w_ur, w_ui, w_dr, w_di;
    logic [W-1:0]           w_mag [4];
    logic [2*W-1:0]         w_rnd [4];
    logic [W:0]             w_q   [4];
    logic [KW-1:0]          w_qs  [4];
    logic [W-1:0]           w_res [4];
    logic [SUMW-1:0]        w_psum;
    logic [SUMW-1:0]        w_pr;
    logic [HWR_PROB_W-1:0]  w_prob;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_o_prob, r_o_pos};

    // ring length in use, clamped
    always_comb begin
        if (r_ring_size < HWR_CFG_W'(2)) begin
            w_len = LW'(2);
        end else if (r_ring_size > HWR_CFG_W'(CAP)) begin
            w_len = LW'(CAP);
        end else begin
            w_len = LW'(r_ring_size);
        end
    end

    assign w_idx_last   = (LW'(r_idx) == r_len - LW'(1));
    assign w_steps_next = r_steps_done + HWR_STEP_W'(1);
    assign w_o_issue    = (r_state == S_OUT) && !r_o_sent && !r_ov1 && !r_ov2 && !r_o_valid;

    // neighbors: up moves right, down moves left, wrapping
    assign w_up_dst = w_idx_last ? '0 : r_idx + AW'(1);
    assign w_dn_dst = (r_idx == '0) ? AW'(r_len - LW'(1)) : r_idx - AW'(1);
    assign w_raddr  = {r_bank, r_idx};

    // control FSM, pipeline valids, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ring_size  <= HWR_CFG_W'(HWR_RING_RESET);
            r_steps      <= '0;
            r_steps_done <= '0;
            r_len        <= LW'(2);
            r_idx        <= '0;
            r_bank       <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_ov1        <= 1'b0;
            r_ov2        <= 1'b0;
            r_o_sent     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ring_size <= i_cfg_data;
            end
            r_v1  <= (r_state == S_STEP);
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_ov1 <= w_o_issue;
            r_ov2 <= r_ov1;
            if (r_ov2) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_steps      <= i_s_axis_tdata[HWR_STEP_W-1:0];
                        r_len        <= w_len;
                        r_idx        <= '0;
                        r_bank       <= 1'b0;
                        r_steps_done <= '0;
                        r_o_sent     <= 1'b0;
                        r_state      <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_state <= (r_steps == '0) ? S_OUT : S_STEP;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_STEP: begin
                    if (w_idx_last) begin
                        r_idx   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DRAIN: begin
                    // last write of this step must land before the next reads
                    if (!r_v1 && !r_v2 && !r_v3) begin
                        r_bank       <= ~r_bank;
                        r_steps_done <= w_steps_next;
                        r_state      <= (w_steps_next == r_steps) ? S_OUT : S_STEP;
                    end
                end
                S_OUT: begin
                    if (w_o_issue) begin
                        if (w_idx_last) begin
                            r_o_sent <= 1'b1;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end
                    if (r_o_valid && i_m_axis_tready && r_o_last) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // memory write select: clear sweep into bank 0, else coin results into other bank
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we       = 1'b1;
            w_up_waddr = {1'b0, r_idx};
            w_dn_waddr = {1'b0, r_idx};
            if (LW'(r_idx) == (r_len >> 1)) begin
                w_up_wdata = {W'(0), W'(COIN_K)};
                w_dn_wdata = {W'(COIN_K), W'(0)};
            end else begin
                w_up_wdata = '0;
                w_dn_wdata = '0;
            end
        end else begin
            w_we       = r_v3;
            w_up_waddr = {~r_bank, r_up_dst3};
            w_dn_waddr = {~r_bank, r_dn_dst3};
            w_up_wdata = {w_res[1], w_res[0]};
            w_dn_wdata = {w_res[3], w_res[2]};
        end
    end

    // amplitude memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_up_mem[w_up_waddr] <= w_up_wdata;
            r_dn_mem[w_dn_waddr] <= w_dn_wdata;
        end
        r_up_rdata <= r_up_mem[w_raddr];
        r_dn_rdata <= r_dn_mem[w_raddr];
    end

    assign w_ur = r_up_rdata[W-1:0];
    assign w_ui = r_up_rdata[2*W-1:W];
    assign w_dr = r_dn_rdata[W-1:0];
    assign w_di = r_dn_rdata[2*W-1:W];

    // coin: magnitude of sums, then rounding and symmetric saturation
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mag[k] = r_sum[k][W] ? W'(-r_sum[k]) : W'(r_sum[k]);
            w_rnd[k] = r_prod[k] + RND_HALF;
            w_q[k]   = w_rnd[k][2*W-1:W-1];
            w_qs[k]  = (w_q[k] > (W + 1)'(AMP_MAX)) ? AMP_MAX : w_q[k][KW-1:0];
            w_res[k] = r_neg[k] ? -W'(w_qs[k]) : W'(w_qs[k]);
        end
    end

    // step pipeline payload: sums, products, destinations
    always_ff @(posedge i_clk) begin
        r_up_dst1 <= w_up_dst;
        r_dn_dst1 <= w_dn_dst;
        r_up_dst2 <= r_up_dst1;
        r_dn_dst2 <= r_dn_dst1;
        r_up_dst3 <= r_up_dst2;
        r_dn_dst3 <= r_dn_dst2;
        r_sum[0]  <= (W + 1)'(w_ur) + (W + 1)'(w_dr);
        r_sum[1]  <= (W + 1)'(w_ui) + (W + 1)'(w_di);
        r_sum[2]  <= (W + 1)'(w_ur) - (W + 1)'(w_dr);
        r_sum[3]  <= (W + 1)'(w_ui) - (W + 1)'(w_di);
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= (2 * W)'(w_mag[k]) * (2 * W)'(COIN_K);
            r_neg[k]  <= r_sum[k][W];
        end
    end

    // probability: sum of squares, scaled to Q0.16, rounded when scaled down
    assign w_psum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]) + SUMW'(r_sq[3]);

    generate
        if (PROB_SH > 0) begin : g_prob_down
            assign w_pr = (w_psum + (SUMW'(1) << (PROB_SH - 1))) >> PROB_SH;
        end else begin : g_prob_up
            assign w_pr = w_psum << (-PROB_SH);
        end
    endgenerate

    assign w_prob = (w_pr > SUMW'(HWR_PROB_MAX)) ? HWR_PROB_W'(HWR_PROB_MAX)
                                                  : w_pr[HWR_PROB_W-1:0];

    // output pipeline payload and output register
    always_ff @(posedge i_clk) begin
        r_op1_pos  <= r_idx;
        r_op1_last <= w_idx_last;
        r_op2_pos  <= r_op1_pos;
        r_op2_last <= r_op1_last;
        r_sq[0]    <= (2 * W)'(w_ur) * (2 * W)'(w_ur);
        r_sq[1]    <= (2 * W)'(w_ui) * (2 * W)'(w_ui);
        r_sq[2]    <= (2 * W)'(w_dr) * (2 * W)'(w_dr);
        r_sq[3]    <= (2 * W)'(w_di) * (2 * W)'(w_di);
        if (r_ov2) begin
            r_o_pos  <= HWR_POS_W'(r_op2_pos);
            r_o_prob <= w_prob;
            r_o_last <= r_op2_last;
        end
    end

    // checks
    `HWR_ASSERT_IMM(a_out_only_in_out, o_m_axis_tvalid, r_state == S_OUT, "beat outside output phase")
    `HWR_ASSERT_IMM(a_no_overwrite, r_ov2, !r_o_valid, "output register overwritten while held")
    `HWR_ASSERT_IMM(a_clear_no_write, r_state == S_CLEAR, !r_v3, "coin write during clear sweep")
    `HWR_ASSERT_IMM(a_step_bound, r_state == S_STEP, r_steps_done < r_steps, "step count overrun")
    `HWR_ASSERT_IMM(a_last_after_all, o_m_axis_tvalid && o_m_axis_tlast, r_o_sent, "tlast early")
    `HWR_ASSERT_NXT(a_start_clear, i_s_axis_tvalid && o_s_axis_tready, r_state == S_CLEAR, "no clear")

endmodule
